FILE: design/fdc_pkg.sv
package fdc_pkg;

  // Default frame size limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Fixed field widths
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int PIX_W     = 8;
  localparam int GRAY_W    = 8;
  localparam int CENT_W    = 10;
  localparam int WSUM_W    = 15;

  // Register reset values
  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Color weights; the weighted sum is divided by W_TOTAL
  localparam logic [WSUM_W-1:0] W_BYTE0 = 15'd11;
  localparam logic [WSUM_W-1:0] W_BYTE1 = 15'd50;
  localparam logic [WSUM_W-1:0] W_BYTE2 = 15'd39;
  localparam logic [WSUM_W-1:0] W_TOTAL = 15'd100;

  // Divide by 100 as multiply by 5243 / 2^19 (exact for sums up to 25500)
  localparam int                RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_MUL  = 13'd5243;
  localparam int                RECIP_SHIFT = 19;

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  // Absolute difference of two pixel bytes
  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: design/fdc_queue.sv
module fdc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  // Store words
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/fdc_front.sv
module fdc_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int CW         = 10,
  parameter int RW         = 10,
  parameter int EW         = 36
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [fdc_pkg::PIX_W-1:0]  cur_byte0,
  input  logic [fdc_pkg::PIX_W-1:0]  cur_byte1,
  input  logic [fdc_pkg::PIX_W-1:0]  cur_byte2,
  input  logic [fdc_pkg::PIX_W-1:0]  bg_byte0,
  input  logic [fdc_pkg::PIX_W-1:0]  bg_byte1,
  input  logic [fdc_pkg::PIX_W-1:0]  bg_byte2,
  input  logic [fdc_pkg::CFG_W-1:0]  frame_width,
  input  logic [fdc_pkg::CFG_W-1:0]  frame_height,
  input  logic                       q_full,
  output logic                       q_wr,
  output logic [EW-1:0]              q_data
);
  import fdc_pkg::*;

  localparam int SZW_A = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int SZW   = ($clog2(MAX_HEIGHT + 1) > SZW_A) ? $clog2(MAX_HEIGHT + 1) : SZW_A;

  logic [CW-1:0]     column_count;
  logic [RW-1:0]     row_count;
  logic [SZW-1:0]    fw_ext;
  logic [SZW-1:0]    fh_ext;
  logic [SZW-1:0]    eff_w;
  logic [SZW-1:0]    eff_h;
  logic              row_end;
  logic              last;
  logic [PIX_W-1:0]  d0;
  logic [PIX_W-1:0]  d1;
  logic [PIX_W-1:0]  d2;
  logic [WSUM_W-1:0] wsum;

  // Clamp the frame size into the supported range
  always_comb begin
    fw_ext = SZW'(frame_width);
    fh_ext = SZW'(frame_height);
    if (fw_ext == '0) begin
      eff_w = SZW'(1);
    end else if (fw_ext > SZW'(MAX_WIDTH)) begin
      eff_w = SZW'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    if (fh_ext == '0) begin
      eff_h = SZW'(1);
    end else if (fh_ext > SZW'(MAX_HEIGHT)) begin
      eff_h = SZW'(MAX_HEIGHT);
    end else begin
      eff_h = fh_ext;
    end
  end

  // Classify the position: row end and frame end
  assign row_end = (SZW'(column_count) >= (eff_w - SZW'(1)));
  assign last    = row_end && (SZW'(row_count) >= (eff_h - SZW'(1)));

  // Weighted sum of the absolute byte differences
  assign d0   = abs_diff(cur_byte0, bg_byte0);
  assign d1   = abs_diff(cur_byte1, bg_byte1);
  assign d2   = abs_diff(cur_byte2, bg_byte2);
  assign wsum = WSUM_W'(d0) * W_BYTE0 + WSUM_W'(d1) * W_BYTE1 + WSUM_W'(d2) * W_BYTE2;

  assign q_wr   = push && !q_full;
  assign q_data = {wsum, last, column_count, row_count};

  // Advance column and row on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (q_wr) begin
      if (last) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (row_end) begin
        column_count <= '0;
        row_count    <= row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

endmodule

FILE: design/fdc_div.sv
module fdc_div #(
  parameter int DW   = 31,
  parameter int CNTW = 21
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [DW-1:0]   dividend_a,
  input  logic [DW-1:0]   dividend_b,
  input  logic [CNTW-1:0] divisor,
  output logic [DW-1:0]   quot_a,
  output logic [DW-1:0]   quot_b,
  output logic            done
);
  localparam int STEP_W = $clog2(DW + 1);

  logic [CNTW-1:0]   dvs;
  logic [CNTW:0]     ra;
  logic [CNTW:0]     rb;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [CNTW:0]     sa;
  logic [CNTW:0]     sb;
  logic              ge_a;
  logic              ge_b;

  // One restoring step for each quotient
  assign sa   = {ra[CNTW-1:0], quot_a[DW-1]};
  assign sb   = {rb[CNTW-1:0], quot_b[DW-1]};
  assign ge_a = (sa >= {1'b0, dvs});
  assign ge_b = (sb >= {1'b0, dvs});

  // Hold the operands and iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quot_a <= dividend_a;
      quot_b <= dividend_b;
      ra     <= '0;
      rb     <= '0;
      dvs    <= divisor;
    end else if (busy) begin
      ra     <= ge_a ? (sa - {1'b0, dvs}) : sa;
      rb     <= ge_b ? (sb - {1'b0, dvs}) : sb;
      quot_a <= {quot_a[DW-2:0], ge_a};
      quot_b <= {quot_b[DW-2:0], ge_b};
    end
  end

  // Step counter and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == STEP_W'(DW - 1));
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: design/fdc_back.sv
module fdc_back #(
  parameter int CW   = 10,
  parameter int RW   = 10,
  parameter int CNTW = 21,
  parameter int DW   = 31,
  parameter int EW   = 36
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  input  logic [EW-1:0]               q_data,
  output logic                        q_rd,
  input  logic                        pop,
  output logic                        empty,
  output logic [fdc_pkg::GRAY_W-1:0]  diff_gray,
  output logic                        frame_end,
  output logic [fdc_pkg::CENT_W-1:0]  centroid_x,
  output logic [fdc_pkg::CENT_W-1:0]  centroid_y,
  output logic                        centroid_valid
);
  import fdc_pkg::*;

  localparam int PROD_W = WSUM_W + RECIP_W;

  back_state_t state;
  back_state_t state_next;

  logic [WSUM_W-1:0]  e_wsum;
  logic               e_last;
  logic [CW-1:0]      e_col;
  logic [RW-1:0]      e_row;
  logic [PROD_W-1:0]  prod;
  logic [GRAY_W-1:0]  gray;
  logic               hit;
  logic [DW-1:0]      column_sum;
  logic [DW-1:0]      row_sum;
  logic [CNTW-1:0]    hit_count;
  logic [DW-1:0]      col_sum_upd;
  logic [DW-1:0]      row_sum_upd;
  logic [CNTW-1:0]    hit_upd;
  logic [GRAY_W-1:0]  gray_hold;
  logic               frame_hit;
  logic               out_free;
  logic               load_pixel;
  logic               load_frame;
  logic               div_start;
  logic [DW-1:0]      quot_a;
  logic [DW-1:0]      quot_b;
  logic               div_done;

  assign {e_wsum, e_last, e_col, e_row} = q_data;

  // Gray value by reciprocal multiply; nonzero exactly when the sum reaches 100
  assign prod = PROD_W'(e_wsum) * PROD_W'(RECIP_MUL);
  assign gray = prod[RECIP_SHIFT +: GRAY_W];
  assign hit  = (e_wsum >= W_TOTAL);

  assign col_sum_upd = hit ? (column_sum + DW'(e_col)) : column_sum;
  assign row_sum_upd = hit ? (row_sum + DW'(e_row)) : row_sum;
  assign hit_upd     = hit ? (hit_count + 1'b1) : hit_count;

  assign out_free = empty || pop;

  fdc_div #(
    .DW   (DW),
    .CNTW (CNTW)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .dividend_a (col_sum_upd),
    .dividend_b (row_sum_upd),
    .divisor    (hit_upd),
    .quot_a     (quot_a),
    .quot_b     (quot_b),
    .done       (div_done)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty && out_free && e_last) begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_rd       = 1'b0;
    load_pixel = 1'b0;
    load_frame = 1'b0;
    div_start  = 1'b0;
    case (state)
      B_IDLE: begin
        q_rd       = !q_empty && out_free;
        load_pixel = q_rd && !e_last;
        div_start  = q_rd && e_last;
      end
      B_DIV: begin
      end
      B_DONE: begin
        load_frame = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulate sums; clear them when the frame closes
  always_ff @(posedge clk) begin
    if (rst) begin
      column_sum <= '0;
      row_sum    <= '0;
      hit_count  <= '0;
    end else if (div_start) begin
      column_sum <= '0;
      row_sum    <= '0;
      hit_count  <= '0;
    end else if (load_pixel) begin
      column_sum <= col_sum_upd;
      row_sum    <= row_sum_upd;
      hit_count  <= hit_upd;
    end
  end

  // Hold the last pixel's gray and the frame's any-hit flag while dividing
  always_ff @(posedge clk) begin
    if (div_start) begin
      gray_hold <= gray;
      frame_hit <= (hit_upd != '0);
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      empty <= 1'b1;
    end else if (load_pixel || load_frame) begin
      empty <= 1'b0;
    end else if (pop) begin
      empty <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_pixel) begin
      diff_gray      <= gray;
      frame_end      <= 1'b0;
      centroid_x     <= '0;
      centroid_y     <= '0;
      centroid_valid <= 1'b0;
    end else if (load_frame) begin
      diff_gray      <= gray_hold;
      frame_end      <= 1'b1;
      centroid_x     <= frame_hit ? quot_a[CENT_W-1:0] : '0;
      centroid_y     <= frame_hit ? quot_b[CENT_W-1:0] : '0;
      centroid_valid <= frame_hit;
    end
  end

endmodule

FILE: design/frame_difference_centroid.sv
// Pixel words: registered in the queue, then the output register; 1 pixel per cycle
//   while the queue is not full and results are popped.
// Frame end: the centroid waits on a bit-serial divider, one quotient bit per cycle,
//   so the last pixel of a frame is poppable only after the divide; the 4-word queue
//   keeps taking pixels meanwhile, until it is full.
// Reset (rst, synchronous): frame size 640 x 480, position and sums cleared, queues empty.
module frame_difference_centroid #(
  parameter int MAX_WIDTH  = fdc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdc_pkg::DEF_MAX_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [fdc_pkg::PIX_W-1:0]     cur_byte0,
  input  logic [fdc_pkg::PIX_W-1:0]     cur_byte1,
  input  logic [fdc_pkg::PIX_W-1:0]     cur_byte2,
  input  logic [fdc_pkg::PIX_W-1:0]     bg_byte0,
  input  logic [fdc_pkg::PIX_W-1:0]     bg_byte1,
  input  logic [fdc_pkg::PIX_W-1:0]     bg_byte2,
  output logic                          empty,
  input  logic                          pop,
  output logic [fdc_pkg::GRAY_W-1:0]    diff_gray,
  output logic                          frame_end,
  output logic [fdc_pkg::CENT_W-1:0]    centroid_x,
  output logic [fdc_pkg::CENT_W-1:0]    centroid_y,
  output logic                          centroid_valid,
  input  logic                          cfg_wr_en,
  input  logic [fdc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [fdc_pkg::CFG_W-1:0]     cfg_wdata
);
  import fdc_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int CNTW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DW     = ((CW > RW) ? CW : RW) + CNTW;
  localparam int EW     = WSUM_W + 1 + CW + RW;
  localparam int Q_DEPTH = 4;

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             q_wr;
  logic             q_rd;
  logic             q_empty;
  logic [EW-1:0]    q_wdata;
  logic [EW-1:0]    q_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_FRAME_WIDTH:  frame_width  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  fdc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .CW         (CW),
    .RW         (RW),
    .EW         (EW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .cur_byte0    (cur_byte0),
    .cur_byte1    (cur_byte1),
    .cur_byte2    (cur_byte2),
    .bg_byte0     (bg_byte0),
    .bg_byte1     (bg_byte1),
    .bg_byte2     (bg_byte2),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .q_full       (full),
    .q_wr         (q_wr),
    .q_data       (q_wdata)
  );

  fdc_queue #(
    .WIDTH (EW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .full    (full),
    .empty   (q_empty)
  );

  fdc_back #(
    .CW   (CW),
    .RW   (RW),
    .CNTW (CNTW),
    .DW   (DW),
    .EW   (EW)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_data         (q_rdata),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .diff_gray      (diff_gray),
    .frame_end      (frame_end),
    .centroid_x     (centroid_x),
    .centroid_y     (centroid_y),
    .centroid_valid (centroid_valid)
  );

  // Centroid fields are zero on words that do not close a frame
  a_mid_frame_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !frame_end) |-> (!centroid_valid && centroid_x == '0 && centroid_y == '0))
    else $error("centroid fields set on a mid-frame word");

  // A valid centroid only rides on a frame end word
  a_valid_at_end: assert property (@(posedge clk) disable iff (rst)
    (!empty && centroid_valid) |-> frame_end)
    else $error("centroid valid without frame end");

  // The back end never reads an empty queue
  a_no_underrun: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_empty)
    else $error("queue read while empty");

  // Reset leaves no word waiting
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result waiting after reset");

endmodule
